FILE: src/b58enc_pkg.sv
// ----------------------------------------------------------------------------
// b58enc_pkg
// Shared types, constants and lookup functions for the base-58 block encoder.
// ----------------------------------------------------------------------------
package b58enc_pkg;

    localparam int BLOCK_BYTES = 8;
    localparam int RADIX       = 58;
    localparam int NUM_DIGITS  = 11;

    // x / 58 == (x >> 1) / 29 == ((x >> 1) * 4520) >> 17 for x < 2^15
    localparam logic [12:0] RECIP_29    = 13'd4520;
    localparam int          RECIP_SHIFT = 17;

    // datapath commands from the controller
    typedef struct packed {
        logic absorb;   // take the offered input byte
        logic conv;     // run one byte step of the divide-by-58 pass
        logic pop;      // the current output character was taken
    } b58enc_cmd_t;

    // datapath status to the controller
    typedef struct packed {
        logic close;      // offered byte ends the block
        logic step_last;  // last byte step of the current digit
        logic conv_last;  // current digit is the most significant one
        logic emit_last;  // current output character ends the block
    } b58enc_sts_t;

    // encoded length for a block of n bytes
    function automatic logic [3:0] chars_for_len(input logic [3:0] n);
        logic [3:0] len;
        case (n)
            4'd1:    len = 4'd2;
            4'd2:    len = 4'd3;
            4'd3:    len = 4'd5;
            4'd4:    len = 4'd6;
            4'd5:    len = 4'd7;
            4'd6:    len = 4'd9;
            4'd7:    len = 4'd10;
            4'd8:    len = 4'd11;
            default: len = 4'd0;
        endcase
        return len;
    endfunction

    // base-58 alphabet: 1-9, A-H, J-N, P-Z, a-k, m-z
    function automatic logic [6:0] digit_char(input logic [5:0] d);
        logic [6:0] dx;
        logic [6:0] c;
        dx = {1'b0, d};
        if (d < 6'd9)
            c = 7'h31 + dx;
        else if (d < 6'd17)
            c = 7'h41 + dx - 7'd9;
        else if (d < 6'd22)
            c = 7'h4A + dx - 7'd17;
        else if (d < 6'd33)
            c = 7'h50 + dx - 7'd22;
        else if (d < 6'd44)
            c = 7'h61 + dx - 7'd33;
        else if (d < 6'd58)
            c = 7'h6D + dx - 7'd44;
        else
            c = 7'h31;
        return c;
    endfunction

endpackage

FILE: src/block_base58_encoder.sv
// ----------------------------------------------------------------------------
// block_base58_encoder
// Streaming base-58 block encoder: bytes in, alphabet characters out.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while the block is idle and packed big-endian
// into a 64-bit accumulator. The eighth byte, or the byte with s_tlast set,
// closes the block; its value is then converted to len = 2,3,5,6,7,9,10,11
// base-58 digits (for 1..8 bytes) by a byte-serial divide-by-58 unit, and
// the characters are sent most significant first, one per cycle while
// m_tready is high, padded with '1'. Input is not taken during conversion
// and output. m_tlast marks the last character of each block, m_tuser the
// last character of the message.
// ----------------------------------------------------------------------------
module block_base58_encoder
    import b58enc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // final_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] char_code, [7] zero
    output logic       m_tlast,   // block_end
    output logic       m_tuser    // [0] message_end
);

    b58enc_cmd_t cmd;
    b58enc_sts_t sts;
    logic [6:0]  char_code;

    b58enc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    b58enc_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_byte     (s_tdata),
        .in_final    (s_tlast),
        .char_code   (char_code),
        .block_end   (m_tlast),
        .message_end (m_tuser)
    );

    assign m_tdata = {1'b0, char_code};

endmodule

FILE: src/b58enc_ctrl.sv
// ----------------------------------------------------------------------------
// b58enc_ctrl
// Sequencer: byte intake, digit conversion pass, character output.
// ----------------------------------------------------------------------------
module b58enc_ctrl
    import b58enc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  b58enc_sts_t sts,
    output b58enc_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.absorb = 1'b1;
                    if (sts.close)
                        state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.conv = 1'b1;
                if (sts.step_last && sts.conv_last)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.pop = 1'b1;
                    if (sts.emit_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/b58enc_dpath.sv
// ----------------------------------------------------------------------------
// b58enc_dpath
// Block accumulator, byte-serial divide-by-58 unit and digit buffer.
// ----------------------------------------------------------------------------
module b58enc_dpath
    import b58enc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  b58enc_cmd_t cmd,
    output b58enc_sts_t sts,
    input  logic [7:0]  in_byte,
    input  logic        in_final,
    output logic [6:0]  char_code,
    output logic        block_end,
    output logic        message_end
);

    logic [63:0] acc_reg;
    logic [3:0]  cnt_reg;
    logic [63:0] work_reg;
    logic [5:0]  rem_reg;
    logic [2:0]  step_reg;
    logic [3:0]  dig_reg;
    logic [3:0]  out_reg;
    logic [3:0]  len_reg;
    logic        last_reg;
    logic [5:0]  digit_reg [NUM_DIGITS];

    logic [63:0] acc_next;
    logic [3:0]  cnt_inc;
    logic [3:0]  len_new;
    logic [13:0] div_x;
    logic [12:0] div_y;
    logic [25:0] div_prod;
    logic [7:0]  div_q;
    logic [13:0] div_r;
    logic [5:0]  rem_next;

    assign acc_next = {acc_reg[55:0], in_byte};
    assign cnt_inc  = cnt_reg + 4'd1;
    assign len_new  = chars_for_len(cnt_inc);

    // one long-division step: remainder and the next dividend byte, MSB first
    assign div_x    = {rem_reg, work_reg[63:56]};
    assign div_y    = div_x[13:1];
    assign div_prod = 26'(div_y) * 26'(RECIP_29);
    assign div_q    = div_prod[RECIP_SHIFT+7:RECIP_SHIFT];
    assign div_r    = div_x - 14'(div_q) * 14'(RADIX);
    assign rem_next = div_r[5:0];

    assign sts.close     = (cnt_inc == 4'(BLOCK_BYTES)) || in_final;
    assign sts.step_last = (step_reg == 3'd7);
    assign sts.conv_last = (dig_reg == 4'd0);
    assign sts.emit_last = (out_reg == len_reg - 4'd1);

    assign char_code   = digit_char(digit_reg[out_reg]);
    assign block_end   = sts.emit_last;
    assign message_end = sts.emit_last && last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            step_reg <= '0;
            dig_reg  <= '0;
            out_reg  <= '0;
        end
        else
        begin
            if (cmd.absorb)
            begin
                if (sts.close)
                begin
                    acc_reg  <= '0;
                    cnt_reg  <= '0;
                    rem_reg  <= '0;
                    step_reg <= '0;
                    dig_reg  <= len_new - 4'd1;
                    out_reg  <= '0;
                end
                else
                begin
                    acc_reg <= acc_next;
                    cnt_reg <= cnt_inc;
                end
            end
            if (cmd.conv)
            begin
                step_reg <= step_reg + 3'd1;
                if (sts.step_last)
                begin
                    rem_reg <= '0;
                    dig_reg <= dig_reg - 4'd1;
                end
                else
                begin
                    rem_reg <= rem_next;
                end
            end
            if (cmd.pop)
                out_reg <= out_reg + 4'd1;
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        if (cmd.absorb && sts.close)
        begin
            work_reg <= acc_next;
            len_reg  <= len_new;
            last_reg <= in_final;
        end
        if (cmd.conv)
        begin
            // quotient bytes refill the word from the bottom
            work_reg <= {work_reg[55:0], div_q};
            if (sts.step_last)
                digit_reg[dig_reg] <= rem_next;
        end
    end

`ifndef SYNTHESIS
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg < 6'(RADIX))
        else $error("remainder out of range");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < 4'(BLOCK_BYTES))
        else $error("byte count out of range");

    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.absorb && sts.close) |=> (acc_reg == 64'd0 && cnt_reg == 4'd0))
        else $error("accumulator not cleared at block close");

    a_pop_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (out_reg < len_reg))
        else $error("output index beyond block length");
`endif

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for block_base58_encoder. Bytes are streamed in as
// messages, each block is encoded by a local model of the base-58 block
// scheme, and every output character is checked in order against it. Both
// stream sides idle at random; the receiver also stalls for a long stretch.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  FULL_BLOCK     = 8;
    localparam int  RADIX          = 58;
    localparam int  DIR_ROWS       = 24;
    localparam int  HOLD_CYCLES    = 400;
    localparam int  WATCHDOG_LIMIT = 4000;
    localparam int  DRAIN_CYCLES   = 40;
    localparam int  MAX_PRINTS     = 40;

    localparam logic [8*58-1:0] B58_ALPHABET =
        "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
    // characters per block of n bytes, n = 0..8, 4 bits each
    localparam logic [4*9-1:0] CHARS_PER_BLOCK =
        {4'd11, 4'd10, 4'd9, 4'd7, 4'd6, 4'd5, 4'd3, 4'd2, 4'd0};

    typedef struct packed {
        logic [7:0] tdata;
        logic       tlast;
        logic       tuser;
    } b58_char_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [7:0] data_byte
    logic       s_tlast = 1'b0;    // final_byte
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [6:0] char_code, [7] zero
    logic       m_tlast;           // block_end
    logic       m_tuser;           // [0] message_end

    // model state
    logic [63:0] block_acc = '0;
    logic [3:0]  block_bytes = '0;
    b58_char_t   pending_chars[$];
    string       fixed_chars_q[$];

    int mismatches   = 0;
    int quiet_cycles = 0;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int hold_req     = 0;
    int hold_ack     = 0;
    int hold_left    = 0;

    logic [8:0] dir_rows [DIR_ROWS];   // {final_byte, data_byte}
    string      dir_chars [DIR_ROWS];

    block_base58_encoder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < MAX_PRINTS)
            $display("mismatch: %s got %0h want %0h", what, got, want);
        mismatches++;
    endtask

    // Pack one byte; on a closing byte queue the block's characters.
    // A non-empty fixed string overrides the computed characters.
    task automatic encode_byte(input logic [7:0] b, input logic fin, input string fixed);
        logic [63:0] val;
        logic [6:0]  digits [11];
        int          len;
        int          k;
        b58_char_t   c;
        block_acc   = {block_acc[55:0], b};
        block_bytes = block_bytes + 4'd1;
        if (block_bytes < FULL_BLOCK && !fin)
            return;
        len = CHARS_PER_BLOCK[4*block_bytes +: 4];
        val = block_acc;
        for (k = len - 1; k >= 0; k--)
        begin
            digits[k] = B58_ALPHABET[8*(57 - int'(val % RADIX)) +: 7];
            val = val / RADIX;
        end
        if (fixed.len() != 0)
        begin
            for (k = 0; k < len; k++)
                digits[k] = 7'(fixed[k]);
        end
        for (k = 0; k < len; k++)
        begin
            c.tdata = {1'b0, digits[k]};
            c.tlast = (k == len - 1);
            c.tuser = (k == len - 1) && fin;
            pending_chars.push_back(c);
        end
        block_acc   = '0;
        block_bytes = '0;
    endtask

    // one request on the input side
    task automatic offer_byte(input logic [7:0] b, input logic fin, input string fixed);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        fixed_chars_q.push_back(fixed);
        s_tdata  <= b;
        s_tlast  <= fin;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_message(input int len);
        int mode;
        int i;
        logic [7:0] b;
        mode = $urandom_range(7);
        for (i = 0; i < len; i++)
        begin
            case (mode)
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = $urandom_range(255);
            endcase
            offer_byte(b, i == len - 1, "");
        end
    endtask

    task automatic send_random(input int count);
        int sent;
        int len;
        sent = 0;
        while (sent < count)
        begin
            // mostly short messages, now and then a few full blocks
            len = ($urandom_range(9) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 10);
            send_message(len);
            sent += len;
        end
    endtask

    // receiver: random tready, or a long stall on request
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin : monitor
        b58_char_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_chars.size() == 0)
                    report_mismatch("character with nothing pending", m_tdata, 0);
                else
                begin
                    want = pending_chars.pop_front();
                    if (m_tdata !== want.tdata)
                        report_mismatch("char_code", m_tdata, want.tdata);
                    if (m_tlast !== want.tlast)
                        report_mismatch("block_end", m_tlast, want.tlast);
                    if (m_tuser !== want.tuser)
                        report_mismatch("message_end", m_tuser, want.tuser);
                end
            end
            if (s_tvalid && s_tready)
                encode_byte(s_tdata, s_tlast, fixed_chars_q.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[block_base58_encoder] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        dir_rows = '{
            9'h100, 9'h1FF,
            9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000,
            9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h1FF,
            9'h012, 9'h034, 9'h156,
            9'h000, 9'h000, 9'h100
        };
        for (i = 0; i < DIR_ROWS; i++)
            dir_chars[i] = "";
        dir_chars[0]  = "11";            // single zero byte
        dir_chars[1]  = "5Q";            // single 0xFF
        dir_chars[9]  = "11111111111";   // full zero block, message goes on
        dir_chars[23] = "11111";         // three zero bytes, final

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 27;
        rx_idle_pct = 83;
        for (i = 0; i < DIR_ROWS; i++)
            offer_byte(dir_rows[i][7:0], dir_rows[i][8], dir_chars[i]);
        send_random(50);

        // let the encoder drain completely before going on
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_chars.size() != 0)
            @(posedge clk);

        tx_idle_pct = 83;
        rx_idle_pct = 27;
        send_random(40);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req++;
        send_message(20);   // keeps offering while output is held off
        send_random(30);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("[block_base58_encoder] OK");
        else
            $display("[block_base58_encoder] ERROR");
        $finish;
    end

endmodule
